// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define SZN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define SZN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SZN_ASSERT(label, prop, msg)
`define SZN_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hw/rtl/szn_pkg.sv =====
// ---------------------------------------------------------------------------
// szn_pkg
// Shared types and fixed widths of the series z-score normaliser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package szn_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned NORM_STEPS = 48;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_VAR_RD,
    ST_VAR_ABS,
    ST_VAR_MUL,
    ST_VAR_ACC,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_NORM_RD,
    ST_NORM_DEV,
    ST_NORM_WAIT,
    ST_NORM_OUT
  } state_t;

endpackage

// ===== hw/rtl/szn_div.sv =====
// ---------------------------------------------------------------------------
// szn_div
// Restoring divider, one quotient bit per cycle. The dividend is given
// left-aligned; once done pulses, the quotient sits in the low steps bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module szn_div #(
  parameter int unsigned DW = 70
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [31:0]                divisor,
  input  logic [$clog2(DW+1)-1:0]    steps,
  output logic                       busy,
  output logic                       done,
  output logic [DW-1:0]              quotient
);

  localparam int unsigned SB = $clog2(DW+1);

  logic [DW-1:0] num;
  logic [31:0]   rem;
  logic [31:0]   dsr;
  logic [SB-1:0] cnt;
  logic [SB-1:0] steps_q;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_diff;
  logic          ge;

  // Trial subtract of one bit step
  always_comb begin
    rem_sh   = {rem, num[DW-1]};
    rem_diff = rem_sh - {1'b0, dsr};
    ge       = (rem_sh >= {1'b0, dsr});
  end

  // Control: run for the requested number of steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == steps_q - 1'b1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the dividend out and the quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      num     <= dividend;
      rem     <= '0;
      dsr     <= divisor;
      steps_q <= steps;
    end else if (busy) begin
      num <= {num[DW-2:0], ge};
      rem <= ge ? rem_diff[31:0] : rem_sh[31:0];
    end
  end

  assign quotient = num;

endmodule

// ===== hw/rtl/series_z_normalizer.sv =====
// ---------------------------------------------------------------------------
// series_z_normalizer
// Stores one series of Q16.16 samples, then emits each as (x - mean) / stdev.
// ---------------------------------------------------------------------------
//  channel | direction | beat                                  | handshake
//  in      | input     | sample                                | in_valid / in_stall
//  out     | output    | normalized, last, flat_series         | out_valid / out_stall
//  cfg     | input     | cfg_wdata (series_length)             | cfg_we
//
// Load: one sample per cycle. Then mean divide, variance pass through VAR_RD,
// VAR_ABS, VAR_MUL and VAR_ACC per sample (memory read, one 32x32 multiply),
// variance divide, bit-serial square root, then each result via the shared
// one-bit-per-cycle divider (skipped when flat). Reset is synchronous and
// clears control state, not the sample memory. A stalled output holds its
// beat and the sequencer waits; the input is stalled through compute and emit.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module series_z_normalizer #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  szn_pkg::cfg_t    cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  szn_pkg::sample_t sample,
  output logic             out_valid,
  input  logic             out_stall,
  output szn_pkg::sample_t normalized,
  output logic             last,
  output logic             flat_series
);

  import szn_pkg::*;

  localparam int unsigned AW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = 32 + AW;
  localparam int unsigned DW = 64 + AW;
  localparam int unsigned SB = $clog2(DW + 1);
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LENGTH);
  localparam logic [CW-1:0] LEN_MIN = CW'(2);

  state_t state, state_next;

  cfg_t                len_cfg;
  logic [CW-1:0]       len_eff;
  logic [CW-1:0]       count;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_next;
  logic [AW-1:0]       idx;
  logic                idx_last;

  logic [31:0]         mem [MAX_LENGTH];
  logic [31:0]         rd_data;
  logic                in_acc;
  logic                out_load;

  logic signed [32:0]  mean;
  logic signed [33:0]  dev;
  logic [33:0]         dev_abs;
  logic [31:0]         abs_dev;
  logic                dev_neg;
  logic [63:0]         prod;
  logic [DW-1:0]       acc;
  logic [SW-1:0]       sum_abs;

  logic [63:0]         sq_v;
  logic [33:0]         sq_rem;
  logic [31:0]         sq_root;
  logic [4:0]          sq_cnt;
  logic [33:0]         sq_rem_sh;
  logic [33:0]         sq_trial;
  logic                flat;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [31:0]         div_divisor;
  logic [SB-1:0]       div_steps;
  logic                div_busy;
  logic                div_done;
  logic [DW-1:0]       div_q;
  logic [NORM_STEPS-1:0] q_norm;
  logic signed [31:0]  z;

  // Clamp the configured length into the supported range
  always_comb begin
    if (len_cfg < CFG_W'(LEN_MIN)) begin
      len_eff = LEN_MIN;
    end else if (len_cfg > CFG_W'(LEN_MAX)) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_cfg[CW-1:0];
    end
  end

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign sum_next = sum + SW'(sample);
  assign idx_last = ({1'b0, idx} == len_eff - 1'b1);
  assign out_load = (state == ST_NORM_OUT) && (!out_valid || !out_stall);
  assign flat     = (sq_root == '0);

  // Sample memory: write on load, registered read at the sequencer index
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[count[AW-1:0]] <= sample;
    end
    rd_data <= mem[idx];
  end

  // Deviation of the sample just read from the mean
  always_comb begin
    dev     = 34'(signed'(rd_data)) - 34'(mean);
    dev_abs = dev[33] ? 34'(-dev) : 34'(dev);
    sum_abs = sum[SW-1] ? SW'(-sum) : SW'(sum);
  end

  // Square root step
  always_comb begin
    sq_rem_sh = {sq_rem[31:0], sq_v[63:62]};
    sq_trial  = {sq_root, 2'b01};
  end

  // Divider operand selection
  always_comb begin
    div_dividend = '0;
    div_divisor  = 32'(len_eff);
    div_steps    = SB'(DW);
    div_start    = 1'b0;
    case (state)
      ST_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = {sum_abs, 32'b0};
        div_steps    = SB'(SW);
      end
      ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = acc;
      end
      ST_NORM_DEV: begin
        div_start    = !flat;
        div_dividend = {dev_abs[31:0], 16'b0, (DW-NORM_STEPS)'(0)};
        div_divisor  = sq_root;
        div_steps    = SB'(NORM_STEPS);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  szn_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturate the quotient and restore the sign
  always_comb begin
    if (dev_neg) begin
      z = (q_norm > NORM_STEPS'(32'h8000_0000)) ? 32'sh8000_0000 :
          32'(-$signed({1'b0, q_norm}));
    end else begin
      z = (q_norm > NORM_STEPS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(q_norm);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (in_acc && (count + 1'b1 == len_eff)) state_next = ST_MEAN_GO;
      ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_next = ST_VAR_RD;
      ST_VAR_RD:    state_next = ST_VAR_ABS;
      ST_VAR_ABS:   state_next = ST_VAR_MUL;
      ST_VAR_MUL:   state_next = ST_VAR_ACC;
      ST_VAR_ACC:   state_next = idx_last ? ST_VAR_GO : ST_VAR_RD;
      ST_VAR_GO:    state_next = ST_VAR_WAIT;
      ST_VAR_WAIT:  if (div_done) state_next = ST_SQRT;
      ST_SQRT:      if (sq_cnt == 5'(SQRT_STEPS - 1)) state_next = ST_NORM_RD;
      ST_NORM_RD:   state_next = ST_NORM_DEV;
      ST_NORM_DEV:  state_next = flat ? ST_NORM_OUT : ST_NORM_WAIT;
      ST_NORM_WAIT: if (div_done) state_next = ST_NORM_OUT;
      ST_NORM_OUT:  if (out_load) state_next = idx_last ? ST_LOAD : ST_NORM_RD;
      default:      state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Length register, sample count and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg <= CFG_W'(64);
      count   <= '0;
      sum     <= '0;
    end else if (cfg_we) begin
      len_cfg <= cfg_wdata;
      count   <= '0;
      sum     <= '0;
    end else if (in_acc) begin
      count <= count + 1'b1;
      sum   <= sum_next;
    end else if (state == ST_MEAN_WAIT && div_done) begin
      count <= '0;
      sum   <= '0;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (state)
        ST_MEAN_WAIT: if (div_done) idx <= '0;
        ST_VAR_ACC:   idx <= idx_last ? '0 : idx + 1'b1;
        ST_NORM_OUT:  if (out_load) idx <= idx_last ? '0 : idx + 1'b1;
        default:      idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MEAN_WAIT: begin
        if (div_done) begin
          mean <= sum[SW-1] ? -$signed({1'b0, div_q[31:0]}) : $signed({1'b0, div_q[31:0]});
          acc  <= '0;
        end
      end
      ST_VAR_ABS: abs_dev <= dev_abs[31:0];
      ST_VAR_MUL: prod    <= abs_dev * abs_dev;
      ST_VAR_ACC: acc     <= acc + DW'(prod);
      ST_VAR_WAIT: begin
        if (div_done) begin
          sq_v    <= div_q[63:0];
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
        end
      end
      ST_SQRT: begin
        sq_v   <= {sq_v[61:0], 2'b00};
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_rem_sh >= sq_trial) begin
          sq_rem  <= sq_rem_sh - sq_trial;
          sq_root <= {sq_root[30:0], 1'b1};
        end else begin
          sq_rem  <= sq_rem_sh;
          sq_root <= {sq_root[30:0], 1'b0};
        end
      end
      ST_NORM_DEV: begin
        dev_neg <= dev[33];
        q_norm  <= '0;
      end
      ST_NORM_WAIT: if (div_done) q_norm <= div_q[NORM_STEPS-1:0];
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      normalized  <= z;
      last        <= idx_last;
      flat_series <= flat;
    end
  end

  `SZN_ASSERT(a_load_count, (state == ST_LOAD) |-> (count < len_eff),
              "sample count reached the series length while loading")
  `SZN_ASSERT(a_flat_zero, (out_valid && flat_series) |-> (normalized == '0),
              "flat series result is not zero")
  `SZN_ASSERT(a_last_gap, (out_valid && last && !out_stall) |=> !out_valid,
              "result follows the final beat of a series too early")
  `SZN_ASSERT(a_div_idle, div_start |-> !div_busy,
              "divider started while busy")

endmodule
